// ===== hdl/lpom_pkg.sv =====
// shared types, constants and helper functions for the low pulse occupancy meter
package lpom_pkg;

    // accumulator width, outputs are masked to OUT_WIDTH bits
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH = 32;
    localparam int WIN_WIDTH = 32;
    localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = WIN_WIDTH'(2000000);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [OUT_WIDTH-1:0] out_word_t;
    typedef logic [WIN_WIDTH-1:0] win_t;

    // one channel's figures for a finished window
    typedef struct packed {
        out_word_t low_time;
        out_word_t total_time;
        out_word_t pulse_count;
    } chan_res_t;

    // one result transaction
    typedef struct packed {
        chan_res_t small_ch;
        chan_res_t large_ch;
    } res_t;

    // increment that sticks at all ones
    function automatic count_t sat_inc(input count_t v, input logic en);
        count_t r;
        r = v;
        if (en && (v != '1))
        begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

    // mask or extend a count to the output width
    function automatic out_word_t to_out(input count_t v);
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] tmp;
        tmp = {{OUT_WIDTH{1'b0}}, v};
        return tmp[OUT_WIDTH-1:0];
    endfunction

endpackage

// ===== hdl/low_pulse_occupancy_meter_core.sv =====
// Low pulse occupancy meter: one tick per cycle while ready, one result per window.
// Each input transaction is one sampling tick carrying the small and large sensor
// levels. Per channel the core counts low ticks, total ticks and low-to-high edges
// (the line is taken as high before the first tick) with saturating counters. When
// the tick that completes a window of window_ticks ticks is taken (zero behaves as
// one), a result transaction carrying all six figures is queued and the counters
// clear. A tick is taken whenever in_ready is high: accumulators and window counter
// update with it, and results pass through a two-entry output buffer, so in_ready
// drops only when two results wait unread. The window length is written through
// cfg_wr_en/cfg_wr_data and applies from the next tick; it resets to 2000000.
module low_pulse_occupancy_meter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        small_level,
    input  logic        large_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] small_low_time,
    output logic [31:0] small_total_time,
    output logic [31:0] small_pulse_count,
    output logic [31:0] large_low_time,
    output logic [31:0] large_total_time,
    output logic [31:0] large_pulse_count
);
    import lpom_pkg::*;

    logic      acc;
    logic      win_end;
    logic      room;
    chan_res_t small_res;
    chan_res_t large_res;
    res_t      res_in;
    res_t      res_out;

    assign in_ready = room;
    assign acc      = in_valid & room;
    assign res_in   = {small_res, large_res};

    // window timing
    lpom_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .acc         (acc),
        .win_end     (win_end)
    );

    // channel accumulators
    lpom_chan u_small (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .level   (small_level),
        .win_end (win_end),
        .res     (small_res)
    );

    lpom_chan u_large (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .level   (large_level),
        .win_end (win_end),
        .res     (large_res)
    );

    // result buffer
    lpom_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc & win_end),
        .push_data (res_in),
        .pop_ready (out_ready),
        .pop_valid (out_valid),
        .pop_data  (res_out),
        .room      (room)
    );

    assign small_low_time    = res_out.small_ch.low_time;
    assign small_total_time  = res_out.small_ch.total_time;
    assign small_pulse_count = res_out.small_ch.pulse_count;
    assign large_low_time    = res_out.large_ch.low_time;
    assign large_total_time  = res_out.large_ch.total_time;
    assign large_pulse_count = res_out.large_ch.pulse_count;

    // a tick that closes the window always leaves a result to read
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && win_end) |=> out_valid)
        else $error("window end did not produce a result");

    // no result appears without a tick being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
        else $error("result appeared without a tick");

    // input side only stalls while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

// ===== hdl/lpom_chan.sv =====
// per-channel low time, total time and rising edge accumulators
module lpom_chan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic              level,
    input  logic              win_end,
    output lpom_pkg::chan_res_t res
);
    import lpom_pkg::*;

    logic   prev_reg;
    count_t low_reg;
    count_t total_reg;
    count_t edge_reg;

    count_t low_next;
    count_t total_next;
    count_t edge_next;

    // figures including this tick; total saturates the same way as low plus high
    always_comb
    begin
        low_next   = sat_inc(low_reg, ~level);
        total_next = sat_inc(total_reg, 1'b1);
        edge_next  = sat_inc(edge_reg, level & ~prev_reg);
        res.low_time    = to_out(low_next);
        res.total_time  = to_out(total_next);
        res.pulse_count = to_out(edge_next);
    end

    // accumulators clear when the window closes, previous level is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b1;
            low_reg   <= '0;
            total_reg <= '0;
            edge_reg  <= '0;
        end
        else if (acc)
        begin
            prev_reg <= level;
            if (win_end)
            begin
                low_reg   <= '0;
                total_reg <= '0;
                edge_reg  <= '0;
            end
            else
            begin
                low_reg   <= low_next;
                total_reg <= total_next;
                edge_reg  <= edge_next;
            end
        end
    end

endmodule

// ===== hdl/lpom_window.sv =====
// window length register and tick counter
module lpom_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  lpom_pkg::win_t        cfg_wr_data,
    input  logic                  acc,
    output logic                  win_end
);
    import lpom_pkg::*;

    win_t window_ticks_reg;
    win_t counter_reg;
    logic [WIN_WIDTH:0] ticks;

    // window closes once the ticks counted, this one included, reach the length
    always_comb
    begin
        ticks   = {1'b0, counter_reg} + {{WIN_WIDTH{1'b0}}, 1'b1};
        win_end = !(ticks < {1'b0, window_ticks_reg});
    end

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_ticks_reg <= cfg_wr_data;
        end
    end

    // tick counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else if (acc)
        begin
            counter_reg <= win_end ? '0 : ticks[WIN_WIDTH-1:0];
        end
    end

endmodule

// ===== hdl/lpom_res_fifo.sv =====
// two-entry result buffer parting the input side from the output side
module lpom_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lpom_pkg::res_t     push_data,
    input  logic               pop_ready,
    output logic               pop_valid,
    output lpom_pkg::res_t     pop_data,
    output logic               room
);
    import lpom_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = pop_valid & pop_ready;
    assign pop_data  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_low_pulse_occupancy_meter_core.sv =====
// testbench for the low pulse occupancy meter core: tick streams checked window by window
module tb_low_pulse_occupancy_meter_core;
    import lpom_pkg::*;

    localparam int GAP_MAX = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_TICKS = 450;

    // running figures of one channel inside the current window
    typedef struct packed {
        logic   prev;
        count_t low;
        count_t high;
        count_t edges;
    } chan_acc_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        small_level = 1'b0;
    logic        large_level = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] small_low_time;
    logic [31:0] small_total_time;
    logic [31:0] small_pulse_count;
    logic [31:0] large_low_time;
    logic [31:0] large_total_time;
    logic [31:0] large_pulse_count;

    // local copy of the meter state
    chan_acc_t small_acc;
    chan_acc_t large_acc;
    win_t      window_len;
    win_t      window_pos;
    res_t      pending_windows[$];

    int unsigned error_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned windows_checked = 0;
    int unsigned window_settings = 0;
    int unsigned cycle_count = 0;
    int unsigned next_gap = 0;
    int unsigned ready_hold = 0;
    bit          valid_kept = 1'b0;
    bit          gaps_off = 1'b0;
    bit          stalls_off = 1'b0;

    low_pulse_occupancy_meter_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .small_level       (small_level),
        .large_level       (large_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .small_low_time    (small_low_time),
        .small_total_time  (small_total_time),
        .small_pulse_count (small_pulse_count),
        .large_low_time    (large_low_time),
        .large_total_time  (large_total_time),
        .large_pulse_count (large_pulse_count)
    );

    // clock generation
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d windows outstanding", cycle_count,
                     pending_windows.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // counter that sticks at all ones
    function automatic count_t count_up(count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    // low plus high, clamped at all ones
    function automatic out_word_t total_of(count_t lo, count_t hi);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[COUNT_WIDTH] ? '1 : out_word_t'(sum[COUNT_WIDTH-1:0]);
    endfunction

    // one tick on one channel
    function automatic chan_acc_t chan_step(chan_acc_t c, logic level);
        chan_acc_t n;
        n = c;
        if (level)
        begin
            n.high = count_up(c.high);
        end
        else
        begin
            n.low = count_up(c.low);
        end
        if (level && !c.prev)
        begin
            n.edges = count_up(c.edges);
        end
        n.prev = level;
        return n;
    endfunction

    function automatic chan_res_t chan_figures(chan_acc_t c);
        chan_res_t r;
        r.low_time = out_word_t'(c.low);
        r.total_time = total_of(c.low, c.high);
        r.pulse_count = out_word_t'(c.edges);
        return r;
    endfunction

    // advance the local meter by one tick, queue a window result when it closes
    function automatic void advance_meter(logic s_lvl, logic l_lvl);
        logic [WIN_WIDTH:0] ticks;
        res_t r;
        small_acc = chan_step(small_acc, s_lvl);
        large_acc = chan_step(large_acc, l_lvl);
        ticks = {1'b0, window_pos} + {{WIN_WIDTH{1'b0}}, 1'b1};
        if (ticks < {1'b0, window_len})
        begin
            window_pos = ticks[WIN_WIDTH-1:0];
        end
        else
        begin
            r.small_ch = chan_figures(small_acc);
            r.large_ch = chan_figures(large_acc);
            pending_windows.push_back(r);
            // previous levels carry over into the next window
            small_acc.low = '0;
            small_acc.high = '0;
            small_acc.edges = '0;
            large_acc.low = '0;
            large_acc.high = '0;
            large_acc.edges = '0;
            window_pos = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at cycle %0d: %s, expected %0d, got %0d", cycle_count, what,
                 want, got);
        error_count++;
    endtask

    task automatic check_field(input string what, input out_word_t want, input out_word_t got);
        if (got !== want)
        begin
            report_mismatch(what, want, got);
        end
    endtask

    // result side: compare each transaction, then draw the next ready hold-off
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_windows.size() == 0)
            begin
                report_mismatch("result with no window pending", '0, small_total_time);
            end
            else
            begin
                want = pending_windows.pop_front();
                windows_checked++;
                check_field("small_low_time", want.small_ch.low_time, small_low_time);
                check_field("small_total_time", want.small_ch.total_time, small_total_time);
                check_field("small_pulse_count", want.small_ch.pulse_count, small_pulse_count);
                check_field("large_low_time", want.large_ch.low_time, large_low_time);
                check_field("large_total_time", want.large_ch.total_time, large_total_time);
                check_field("large_pulse_count", want.large_ch.pulse_count, large_pulse_count);
            end
            ready_hold = stalls_off ? 0 : $urandom_range(0, GAP_MAX);
        end
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // send one tick transaction; valid stays up only when the next one follows at once
    task automatic send_tick(input logic s_lvl, input logic l_lvl);
        if (!valid_kept)
        begin
            repeat (next_gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        small_level <= s_lvl;
        large_level <= l_lvl;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        advance_meter(s_lvl, l_lvl);
        ticks_sent++;
        next_gap = gaps_off ? 0 : $urandom_range(0, GAP_MAX);
        valid_kept = (next_gap == 0);
        if (!valid_kept)
        begin
            in_valid <= 1'b0;
        end
    endtask

    task automatic release_input();
        if (valid_kept)
        begin
            in_valid <= 1'b0;
            valid_kept = 1'b0;
            next_gap = 1;
        end
    endtask

    // hold the sender until every pending window has come out
    task automatic wait_results();
        release_input();
        @(posedge clk);
        while (pending_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input win_t len);
        wait_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_len = len;
        window_settings++;
    endtask

    // line taken as high before the first tick, so a high first sample is no edge
    task automatic test_first_tick_high();
        set_window(5);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_one_tick_window();
        set_window(1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // zero length behaves like a one tick window
    task automatic test_zero_window();
        set_window('0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
    endtask

    // shorter window written mid-window closes on the next tick
    task automatic test_shortened_window();
        set_window(8);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        set_window(2);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_longest_window();
        set_window('1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        set_window(1);
        send_tick(1'b1, 1'b1);
    endtask

    // random windows filled with pulse trains of random run lengths
    task automatic test_random_windows();
        int unsigned goal;
        int unsigned burst;
        int unsigned s_run;
        int unsigned l_run;
        logic        s_cur;
        logic        l_cur;
        win_t        len;
        goal = ticks_sent + RANDOM_TICKS;
        s_run = 0;
        l_run = 0;
        s_cur = 1'b1;
        l_cur = 1'b1;
        while (ticks_sent < goal)
        begin
            case ($urandom_range(0, 9))
                0: len = '0;
                1: len = 1;
                2, 3: len = $urandom_range(13, 40);
                default: len = $urandom_range(2, 12);
            endcase
            gaps_off = ($urandom_range(0, 3) == 0);
            stalls_off = ($urandom_range(0, 3) == 0);
            set_window(len);
            burst = $urandom_range(8, 40);
            for (int unsigned k = 0; k < burst; k++)
            begin
                if (s_run == 0)
                begin
                    s_cur = 1'($urandom_range(0, 1));
                    s_run = $urandom_range(1, 6);
                end
                if (l_run == 0)
                begin
                    l_cur = 1'($urandom_range(0, 1));
                    l_run = $urandom_range(1, 6);
                end
                s_run--;
                l_run--;
                send_tick(s_cur, l_cur);
                if ($urandom_range(0, 60) == 0)
                begin
                    wait_results();
                end
            end
        end
        gaps_off = 1'b0;
        stalls_off = 1'b0;
    endtask

    // test sequence
    initial
    begin
        small_acc = '0;
        small_acc.prev = 1'b1;
        large_acc = '0;
        large_acc.prev = 1'b1;
        window_len = WINDOW_RESET;
        window_pos = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_first_tick_high();
        test_one_tick_window();
        test_zero_window();
        test_shortened_window();
        test_longest_window();
        test_random_windows();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d ticks sent over %0d window settings (zero, one and full range among them)",
                 ticks_sent, window_settings);
        $display("%0d window results compared, %0d mismatches", windows_checked, error_count);
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
